FILE: sv/nps_pkg.sv
// Shared constants and types for the next prime search block.
package nps_pkg;

  // Width of the searched values; fields wider than this are truncated on entry.
  localparam int VALUE_WIDTH = 32;
  // Width of the port fields.
  localparam int PORT_WIDTH = 32;
  // Bit counter width for one serial remainder pass.
  localparam int CNT_WIDTH = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;
  // Square of the divisor needs two extra bits of headroom.
  localparam int SQ_WIDTH = VALUE_WIDTH + 2;

  // Search sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_TEST,
    ST_DIV,
    ST_EVAL,
    ST_NEXT,
    ST_FIN
  } state_t;

endpackage

FILE: sv/next_prime_search.sv
// Top level of the next prime search: serial trial division sequencer.
//
// Takes one start value per word and returns the smallest prime at or above
// it; starts of 0, 1 and 2 come back unchanged, and when no prime fits in
// nps_pkg::VALUE_WIDTH bits the word carries overflow = 1 and a value of 0.
// Only one start value is searched at a time; a new word is taken as soon as
// the previous result has moved into the output register, even if that result
// is still stalled. The search time is data dependent: a start below 3 skips
// the search, even candidates are skipped, and each odd candidate is tried
// against odd divisors from 3 up to its square root until one divides it.
// The remainder for each divisor is formed one bit per cycle in a restoring
// shift-subtract unit, and that unit sets the pace of the search.
module next_prime_search (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [nps_pkg::PORT_WIDTH-1:0]  in_start_value,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [nps_pkg::PORT_WIDTH-1:0]  out_prime_value,
  output logic                            out_overflow
);

  localparam int W  = nps_pkg::VALUE_WIDTH;
  localparam int SW = nps_pkg::SQ_WIDTH;
  localparam int CW = nps_pkg::CNT_WIDTH;

  nps_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;

  logic [W-1:0]    cand_r, cand_nxt;
  logic [W-1:0]    div_r, div_nxt;
  logic [SW-1:0]   sq_r, sq_nxt;
  logic [W-1:0]    sh_r, sh_nxt;
  logic [W:0]      rem_r, rem_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [W-1:0]    res_r, res_nxt;
  logic            res_ovf_r, res_ovf_nxt;
  logic [nps_pkg::PORT_WIDTH-1:0] oval_r, oval_nxt;
  logic            oovf_r, oovf_nxt;

  logic [W:0]      rem_shift;
  logic [W:0]      rem_sub;
  logic            rem_ge;
  logic [W-1:0]    start_w;
  logic            out_free;

  // Truncate the start value to the search width.
  assign start_w   = in_start_value[W-1:0];
  // Shift one candidate bit into the partial remainder and trial subtract.
  assign rem_shift = {rem_r[W-1:0], sh_r[W-1]};
  assign rem_ge    = rem_shift >= {1'b0, div_r};
  assign rem_sub   = rem_shift - {1'b0, div_r};
  assign out_free  = !out_valid_r || !out_stall;

  // Next state and datapath updates.
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cand_nxt      = cand_r;
    div_nxt       = div_r;
    sq_nxt        = sq_r;
    sh_nxt        = sh_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    res_nxt       = res_r;
    res_ovf_nxt   = res_ovf_r;
    oval_nxt      = oval_r;
    oovf_nxt      = oovf_r;

    // Drop the output word once the receiver takes it.
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      nps_pkg::ST_IDLE: begin
        if (in_valid) begin
          cand_nxt = start_w;
          if (start_w <= W'(2)) begin
            res_nxt     = start_w;
            res_ovf_nxt = 1'b0;
            state_nxt   = nps_pkg::ST_FIN;
          end else begin
            state_nxt = nps_pkg::ST_CHECK;
          end
        end
      end
      nps_pkg::ST_CHECK: begin
        // Skip even candidates; start odd ones at divisor 3.
        if (!cand_r[0]) begin
          state_nxt = nps_pkg::ST_NEXT;
        end else begin
          div_nxt   = W'(3);
          sq_nxt    = SW'(9);
          state_nxt = nps_pkg::ST_TEST;
        end
      end
      nps_pkg::ST_TEST: begin
        // Divisor past the square root: the candidate is prime.
        if (sq_r > {2'b00, cand_r}) begin
          res_nxt     = cand_r;
          res_ovf_nxt = 1'b0;
          state_nxt   = nps_pkg::ST_FIN;
        end else begin
          sh_nxt    = cand_r;
          rem_nxt   = '0;
          cnt_nxt   = CW'(W - 1);
          state_nxt = nps_pkg::ST_DIV;
        end
      end
      nps_pkg::ST_DIV: begin
        // Advance the remainder by one candidate bit.
        rem_nxt = rem_ge ? rem_sub : rem_shift;
        sh_nxt  = {sh_r[W-2:0], 1'b0};
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == '0) begin
          state_nxt = nps_pkg::ST_EVAL;
        end
      end
      nps_pkg::ST_EVAL: begin
        if (rem_r == '0) begin
          state_nxt = nps_pkg::ST_NEXT;
        end else begin
          // (d + 2)^2 = d^2 + 4d + 4
          div_nxt   = div_r + W'(2);
          sq_nxt    = sq_r + {div_r, 2'b00} + SW'(4);
          state_nxt = nps_pkg::ST_TEST;
        end
      end
      nps_pkg::ST_NEXT: begin
        // Top of the range reached without a prime: report overflow.
        if (cand_r == '1) begin
          res_nxt     = '0;
          res_ovf_nxt = 1'b1;
          state_nxt   = nps_pkg::ST_FIN;
        end else begin
          cand_nxt  = cand_r + W'(1);
          state_nxt = nps_pkg::ST_CHECK;
        end
      end
      nps_pkg::ST_FIN: begin
        // Hold the result until the output register is free.
        if (out_free) begin
          oval_nxt      = nps_pkg::PORT_WIDTH'(res_r);
          oovf_nxt      = res_ovf_r;
          out_valid_nxt = 1'b1;
          state_nxt     = nps_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = nps_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= nps_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    cand_r    <= cand_nxt;
    div_r     <= div_nxt;
    sq_r      <= sq_nxt;
    sh_r      <= sh_nxt;
    rem_r     <= rem_nxt;
    cnt_r     <= cnt_nxt;
    res_r     <= res_nxt;
    res_ovf_r <= res_ovf_nxt;
    oval_r    <= oval_nxt;
    oovf_r    <= oovf_nxt;
  end

  assign in_stall        = (state_r != nps_pkg::ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_prime_value = oval_r;
  assign out_overflow    = oovf_r;

endmodule

FILE: dv/tb_next_prime_search.sv
// Self-checking testbench for the next prime search block.
`timescale 1ns / 1ps

module tb_next_prime_search;

  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int TAIL_CYCLES = 100;
  localparam int REPORT_MAX  = 10;

  typedef struct {
    logic [nps_pkg::PORT_WIDTH-1:0] prime_value;
    logic                           overflow;
  } prime_result_t;

  logic                           clk;
  logic                           rst_n          = 1'b0;
  logic                           in_valid       = 1'b0;
  logic                           in_stall;
  logic [nps_pkg::PORT_WIDTH-1:0] in_start_value = '0;
  logic                           out_valid;
  logic                           out_stall      = 1'b0;
  logic [nps_pkg::PORT_WIDTH-1:0] out_prime_value;
  logic                           out_overflow;

  logic [nps_pkg::PORT_WIDTH-1:0] start_words[$];
  prime_result_t                  expected_primes[$];

  int send_idle_pct = 26;
  int recv_idle_pct = 76;
  int fail_count    = 0;
  int cycle_count   = 0;

  next_prime_search dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_start_value  (in_start_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_prime_value (out_prime_value),
    .out_overflow    (out_overflow)
  );

  // Smallest prime at or above the masked start, or overflow when none fits.
  function automatic prime_result_t next_prime_of(
    logic [nps_pkg::PORT_WIDTH-1:0] start_word
  );
    logic [63:0]   top;
    logic [63:0]   cand;
    logic [63:0]   div;
    bit            is_prime;
    prime_result_t res;
    top             = (64'd1 << nps_pkg::VALUE_WIDTH) - 64'd1;
    cand            = 64'(start_word) & top;
    res.prime_value = '0;
    res.overflow    = 1'b1;
    if (cand <= 64'd2) begin
      res.prime_value = cand[nps_pkg::PORT_WIDTH-1:0];
      res.overflow    = 1'b0;
      return res;
    end
    while (cand <= top) begin
      if (cand[0]) begin
        is_prime = 1'b1;
        div      = 64'd3;
        while (is_prime && div * div <= cand) begin
          if (cand % div == 64'd0) is_prime = 1'b0;
          div += 64'd2;
        end
        if (is_prime) begin
          res.prime_value = cand[nps_pkg::PORT_WIDTH-1:0];
          res.overflow    = 1'b0;
          return res;
        end
      end
      cand += 64'd1;
    end
    return res;
  endfunction

  // Wait until every queued word has been taken and every result has come back.
  task automatic wait_drained();
    while (start_words.size() != 0 || in_valid || expected_primes.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Predict on acceptance, then offer the next word or idle.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) expected_primes.push_back(next_prime_of(in_start_value));
      if (start_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid       <= 1'b1;
        in_start_value <= start_words.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Check each accepted result word against the oldest prediction.
  always @(posedge clk) begin
    prime_result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_primes.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_MAX)
            $display("unexpected result word: prime_value=%0d overflow=%0b",
                     out_prime_value, out_overflow);
        end else begin
          want = expected_primes.pop_front();
          if (out_prime_value !== want.prime_value || out_overflow !== want.overflow) begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
              $display("mismatch: expected prime_value=%0d overflow=%0b, got %0d %0b",
                       want.prime_value, want.overflow, out_prime_value, out_overflow);
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Stop a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int pick;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: pass-through starts, small primes and gaps, top-of-range overflow.
    start_words.push_back(32'd0);
    start_words.push_back(32'd1);
    start_words.push_back(32'd2);
    start_words.push_back(32'd3);
    start_words.push_back(32'd4);
    start_words.push_back(32'd5);
    start_words.push_back(32'd8);
    start_words.push_back(32'd9);
    start_words.push_back(32'd24);
    start_words.push_back(32'd89);
    start_words.push_back(32'd114);
    start_words.push_back(32'd1000);
    start_words.push_back(32'd4093);
    start_words.push_back(32'd32768);
    start_words.push_back(32'd65535);
    start_words.push_back(32'hFFFF_FFFF);
    start_words.push_back(32'hFFFF_FFFE);
    start_words.push_back(32'hFFFF_FFFC);
    start_words.push_back(32'd2);
    start_words.push_back(32'd7);
    // Hold the sender until the block has answered everything.
    wait_drained();

    // Random: mostly small starts so the trial division stays short.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 26;
          recv_idle_pct = 76;
        end
        1: begin
          send_idle_pct = 76;
          recv_idle_pct = 26;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int i = 0; i < 34; i++) begin
        pick = $urandom_range(99);
        if (pick < 70)
          start_words.push_back(nps_pkg::PORT_WIDTH'($urandom_range(4095)));
        else if (pick < 88)
          start_words.push_back(nps_pkg::PORT_WIDTH'($urandom_range(65535)));
        else if (pick < 95)
          start_words.push_back(nps_pkg::PORT_WIDTH'($urandom_range(2)));
        else
          start_words.push_back(32'hFFFF_FFFF - nps_pkg::PORT_WIDTH'($urandom_range(1)));
      end
      wait_drained();
    end

    // Let any stray result word show up before deciding.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && expected_primes.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
